FILE: hdl/b64d_pkg.sv
package b64d_pkg;

  localparam logic [7:0] PAD_CHAR = 8'h3D;

  localparam logic [1:0] KIND_DATA = 2'd0;
  localparam logic [1:0] KIND_PAD  = 2'd1;
  localparam logic [1:0] KIND_BAD  = 2'd2;

  localparam int QUEUE_DEPTH = 2;
  localparam int PTR_W       = $clog2(QUEUE_DEPTH);
  localparam int COUNT_W     = $clog2(QUEUE_DEPTH + 1);

  typedef struct packed {
    logic [1:0] kind;
    logic [5:0] sextet;
    logic       eot;
  } b64d_rec_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       byte_valid;
    logic       last_result;
    logic       bad_input;
  } b64d_res_t;

  function automatic b64d_rec_t classify(input logic [7:0] c, input logic eot);
    b64d_rec_t  r;
    logic [7:0] t;
    r.eot    = eot;
    r.kind   = KIND_DATA;
    t        = 8'd0;
    case (c) inside
      [8'h41:8'h5A]: t = c - 8'd65;
      [8'h61:8'h7A]: t = c - 8'd71;
      [8'h30:8'h39]: t = c + 8'd4;
      8'h2B:         t = 8'd62;
      8'h2F:         t = 8'd63;
      PAD_CHAR:      r.kind = KIND_PAD;
      default:       r.kind = KIND_BAD;
    endcase
    r.sextet = t[5:0];
    return r;
  endfunction

endpackage

FILE: hdl/b64d_front.sv
module b64d_front
  import b64d_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  output logic       full,
  input  logic [7:0] char_code,
  input  logic       end_of_text,
  output b64d_rec_t  rec,
  output logic       rec_valid,
  input  logic       rec_take
);

  b64d_rec_t          mem [QUEUE_DEPTH];
  logic [PTR_W-1:0]   wptr;
  logic [PTR_W-1:0]   rptr;
  logic [COUNT_W-1:0] count;
  logic               do_push;
  logic               do_take;

  assign full      = (count == COUNT_W'(QUEUE_DEPTH));
  assign rec_valid = (count != '0);
  assign rec       = mem[rptr];
  assign do_push   = push && !full;
  assign do_take   = rec_take && rec_valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wptr] <= classify(char_code, end_of_text);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (do_push) begin
        wptr <= PTR_W'(wptr + 1'b1);
      end
      if (do_take) begin
        rptr <= PTR_W'(rptr + 1'b1);
      end
      case ({do_push, do_take})
        2'b10:   count <= COUNT_W'(count + 1'b1);
        2'b01:   count <= COUNT_W'(count - 1'b1);
        default: count <= count;
      endcase
    end
  end

endmodule

FILE: hdl/b64d_back.sv
module b64d_back
  import b64d_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  b64d_rec_t  rec,
  input  logic       rec_valid,
  output logic       rec_take,
  output logic       empty,
  input  logic       pop,
  output b64d_res_t  res
);

  logic [1:0]         group_position;
  logic [5:0]         held_sextet;
  logic               pad_seen;
  b64d_res_t          mem [QUEUE_DEPTH];
  logic [PTR_W-1:0]   wptr;
  logic [PTR_W-1:0]   rptr;
  logic [COUNT_W-1:0] count;
  logic               do_pop;
  logic               room;
  logic               is_bad;
  logic               is_pad;
  logic               is_data;
  logic               emit;
  logic               do_push;
  b64d_res_t          res_next;

  assign empty    = (count == '0);
  assign res      = mem[rptr];
  assign do_pop   = pop && !empty;
  assign room     = (count != COUNT_W'(QUEUE_DEPTH)) || do_pop;
  assign rec_take = rec_valid && room;

  assign is_bad  = (rec.kind == KIND_BAD) || ((rec.kind == KIND_DATA) && pad_seen);
  assign is_pad  = (rec.kind == KIND_PAD);
  assign is_data = !is_bad && !is_pad;

  always_comb begin
    res_next = '0;
    res_next.last_result = rec.eot;
    res_next.bad_input   = is_bad;
    if (is_data) begin
      case (group_position)
        2'd1: begin
          res_next.data_byte  = {held_sextet, rec.sextet[5:4]};
          res_next.byte_valid = 1'b1;
        end
        2'd2: begin
          res_next.data_byte  = {held_sextet[3:0], rec.sextet[5:2]};
          res_next.byte_valid = 1'b1;
        end
        2'd3: begin
          res_next.data_byte  = {held_sextet[1:0], rec.sextet};
          res_next.byte_valid = 1'b1;
        end
        default: res_next.byte_valid = 1'b0;
      endcase
    end
  end

  assign emit    = res_next.last_result || res_next.byte_valid || res_next.bad_input;
  assign do_push = rec_take && emit;

  always_ff @(posedge clk) begin
    if (rst) begin
      group_position <= '0;
      held_sextet    <= '0;
      pad_seen       <= 1'b0;
    end else if (rec_take) begin
      if (rec.eot) begin
        group_position <= '0;
        held_sextet    <= '0;
        pad_seen       <= 1'b0;
      end else if (is_pad) begin
        pad_seen       <= 1'b1;
        group_position <= 2'(group_position + 1'b1);
      end else if (is_data) begin
        held_sextet    <= rec.sextet;
        group_position <= 2'(group_position + 1'b1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wptr] <= res_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (do_push) begin
        wptr <= PTR_W'(wptr + 1'b1);
      end
      if (do_pop) begin
        rptr <= PTR_W'(rptr + 1'b1);
      end
      case ({do_push, do_pop})
        2'b10:   count <= COUNT_W'(count + 1'b1);
        2'b01:   count <= COUNT_W'(count - 1'b1);
        default: count <= count;
      endcase
    end
  end

  a_no_overfill: assert property (@(posedge clk) disable iff (rst)
    count <= COUNT_W'(QUEUE_DEPTH))
    else $error("result queue overfilled");

  a_eot_clears: assert property (@(posedge clk) disable iff (rst)
    rec_take && rec.eot |=> group_position == '0 && !pad_seen && held_sextet == '0)
    else $error("state not cleared after end of text");

  a_eot_emits: assert property (@(posedge clk) disable iff (rst)
    rec_take && rec.eot |-> do_push)
    else $error("end of text gave no word");

  a_data_after_pad: assert property (@(posedge clk) disable iff (rst)
    rec_take && pad_seen && rec.kind == KIND_DATA |-> do_push && !res_next.byte_valid)
    else $error("data after pad produced a byte");

  a_head_flags: assert property (@(posedge clk) disable iff (rst)
    !empty |-> !(res.byte_valid && res.bad_input))
    else $error("word both valid and bad");

endmodule

FILE: hdl/base64_stream_decoder_core.sv
// Streaming Base64 decoder, standard alphabet with '=' padding.
// Input side is a queue write port: present char_code and end_of_text with
// push high; the word is taken at a rising edge with push high and full low.
// Result side is a queue read port: while empty is low the oldest result sits
// on data_byte, byte_valid, last_result and bad_input; pop high at a rising
// edge with empty low removes it.
// A character gives a result only when it completes a byte or is bad; an
// end-of-text character always gives one result with last_result set, after
// which the group position, held sextet and pad flag return to zero.
// A taken character is registered in the classify queue; assembly then takes
// it when the result queue has room and writes its result straight into that queue.
// Throughput: one character per cycle while the result queue has room.
// Each side holds a two-word queue, so a stalled reader first fills the result
// queue, then the input queue, and only then raises full; nothing is dropped.
// Reset (rst, synchronous) empties both queues and clears the decoder state.
module base64_stream_decoder_core
  import b64d_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  output logic       full,
  input  logic [7:0] char_code,
  input  logic       end_of_text,
  output logic       empty,
  input  logic       pop,
  output logic [7:0] data_byte,
  output logic       byte_valid,
  output logic       last_result,
  output logic       bad_input
);

  b64d_rec_t rec;
  logic      rec_valid;
  logic      rec_take;
  b64d_res_t res;

  b64d_front u_front (
    .clk         (clk),
    .rst         (rst),
    .push        (push),
    .full        (full),
    .char_code   (char_code),
    .end_of_text (end_of_text),
    .rec         (rec),
    .rec_valid   (rec_valid),
    .rec_take    (rec_take)
  );

  b64d_back u_back (
    .clk       (clk),
    .rst       (rst),
    .rec       (rec),
    .rec_valid (rec_valid),
    .rec_take  (rec_take),
    .empty     (empty),
    .pop       (pop),
    .res       (res)
  );

  assign data_byte   = res.data_byte;
  assign byte_valid  = res.byte_valid;
  assign last_result = res.last_result;
  assign bad_input   = res.bad_input;

endmodule

FILE: verif/tb_base64_stream_decoder_core.sv
`timescale 1ns / 1ps

module tb_base64_stream_decoder_core;
  import b64d_pkg::*;

  localparam int QUIET_LIMIT = 2000;
  localparam int N_CHARS     = 1250;

  class b64_scoreboard;
    logic [1:0] grp_pos;
    logic [5:0] prev_sextet;
    bit         pad_flag;
    b64d_res_t  due_q[$];
    int         errors;

    function new();
      grp_pos     = '0;
      prev_sextet = '0;
      pad_flag    = 1'b0;
      errors      = 0;
    endfunction

    function void report(string what, int exp_v, int got_v);
      errors++;
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, what, exp_v, got_v);
    endfunction

    function void note_char(logic [7:0] c, logic eot);
      logic [7:0] t;
      logic [5:0] sx;
      bit         is_pad;
      bit         is_bad;
      b64d_res_t  r;
      t      = 8'd0;
      is_pad = 1'b0;
      is_bad = 1'b0;
      if (c >= "A" && c <= "Z") t = c - "A";
      else if (c >= "a" && c <= "z") t = c - "a" + 8'd26;
      else if (c >= "0" && c <= "9") t = c - "0" + 8'd52;
      else if (c == "+") t = 8'd62;
      else if (c == "/") t = 8'd63;
      else if (c == PAD_CHAR) is_pad = 1'b1;
      else is_bad = 1'b1;
      sx = t[5:0];
      r  = '0;
      if (is_bad || (!is_pad && pad_flag)) begin
        r.bad_input = 1'b1;
      end else if (is_pad) begin
        pad_flag = 1'b1;
        grp_pos  = grp_pos + 2'd1;
      end else begin
        case (grp_pos)
          2'd1: begin
            r.data_byte  = {prev_sextet, sx[5:4]};
            r.byte_valid = 1'b1;
          end
          2'd2: begin
            r.data_byte  = {prev_sextet[3:0], sx[5:2]};
            r.byte_valid = 1'b1;
          end
          2'd3: begin
            r.data_byte  = {prev_sextet[1:0], sx};
            r.byte_valid = 1'b1;
          end
          default: ;
        endcase
        prev_sextet = sx;
        grp_pos     = grp_pos + 2'd1;
      end
      if (eot) begin
        grp_pos     = '0;
        prev_sextet = '0;
        pad_flag    = 1'b0;
        r.last_result = 1'b1;
      end
      if (r.byte_valid || r.bad_input || r.last_result) due_q.push_back(r);
    endfunction

    function void check_word(b64d_res_t got);
      b64d_res_t want;
      if (due_q.size() == 0) begin
        report("unexpected word", 0, int'(got));
      end else begin
        want = due_q.pop_front();
        if (got.data_byte !== want.data_byte)
          report("data_byte", want.data_byte, got.data_byte);
        if (got.byte_valid !== want.byte_valid)
          report("byte_valid", want.byte_valid, got.byte_valid);
        if (got.last_result !== want.last_result)
          report("last_result", want.last_result, got.last_result);
        if (got.bad_input !== want.bad_input)
          report("bad_input", want.bad_input, got.bad_input);
      end
    endfunction
  endclass

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       push = 1'b0;
  logic       full;
  logic [7:0] char_code = 8'd0;
  logic       end_of_text = 1'b0;
  logic       empty;
  logic       pop = 1'b0;
  logic [7:0] data_byte;
  logic       byte_valid;
  logic       last_result;
  logic       bad_input;

  b64_scoreboard sb = new();
  bit            steady = 1'b0;
  int            sent = 0;
  int            quiet_cycles = 0;

  base64_stream_decoder_core u_dut (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .full       (full),
    .char_code  (char_code),
    .end_of_text(end_of_text),
    .empty      (empty),
    .pop        (pop),
    .data_byte  (data_byte),
    .byte_valid (byte_valid),
    .last_result(last_result),
    .bad_input  (bad_input)
  );

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  always @(negedge clk) begin
    if (rst) pop <= 1'b0;
    else pop <= steady || ($urandom_range(99) >= 19);
  end

  always @(posedge clk) begin
    if (rst) begin
      quiet_cycles = 0;
    end else begin
      if (pop && !empty) sb.check_word(b64d_res_t'{data_byte, byte_valid, last_result, bad_input});
      if ((push && !full) || (pop && !empty)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("status: fail");
        $finish;
      end
    end
  end

  // call at a falling edge; returns at the falling edge after the word is taken
  task automatic put_char(input logic [7:0] c, input logic eot);
    while (!steady && $urandom_range(99) < 19) begin
      push = 1'b0;
      @(negedge clk);
    end
    push        = 1'b1;
    char_code   = c;
    end_of_text = eot;
    do @(posedge clk); while (full);
    sb.note_char(c, eot);
    sent++;
    steady = (sent >= 500 && sent < 800);
    @(negedge clk);
  endtask

  task automatic put_string(input string s, input bit eot_at_end);
    for (int i = 0; i < s.len(); i++) put_char(s[i], eot_at_end && (i == s.len() - 1));
  endtask

  initial begin
    logic [7:0] odd_chars[7];
    logic [7:0] text[$];
    string      alphabet;
    int         kind;
    int         n_grp;
    int         tail;
    int         len;
    alphabet  = "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";
    odd_chars = '{8'h00, 8'hFF, 8'h40, 8'h5B, 8'h60, 8'h7B, 8'h3A};
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    put_string("TWFu", 1'b1);
    put_string("+/9Aza0Z", 1'b1);
    put_string("TWF=Q==", 1'b1);
    foreach (odd_chars[i]) put_char(odd_chars[i], i == 6);

    while (sent < N_CHARS) begin
      kind = $urandom_range(9);
      if (kind == 9) begin
        len = $urandom_range(1, 12);
        repeat (len) put_char(8'($urandom_range(255)), $urandom_range(9) == 0);
      end else begin
        text.delete();
        n_grp = $urandom_range(3);
        tail  = $urandom_range(3);
        if (tail == 1 && kind < 7) tail = 2;
        repeat (4 * n_grp + tail) text.push_back(alphabet[$urandom_range(63)]);
        if (kind >= 2) begin
          if (tail == 2) repeat (2) text.push_back(PAD_CHAR);
          if (tail == 3) text.push_back(PAD_CHAR);
        end
        if (text.size() == 0) text.push_back(alphabet[$urandom_range(63)]);
        if (kind >= 7) begin
          if ($urandom_range(1)) text[$urandom_range(text.size() - 1)] = 8'($urandom_range(255));
          else text.insert($urandom_range(text.size() - 1), PAD_CHAR);
        end
        foreach (text[i]) put_char(text[i], i == text.size() - 1);
      end
    end
    push = 1'b0;

    while (sb.due_q.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (sb.errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

FILE: base64_stream_decoder_core.f
hdl/b64d_pkg.sv
hdl/b64d_front.sv
hdl/b64d_back.sv
hdl/base64_stream_decoder_core.sv
verif/tb_base64_stream_decoder_core.sv
